### rtl/tmd_pkg.sv
// tmd_pkg: shared constants, types and functions of the text message deframer
package tmd_pkg;

  localparam int LINE_CHARS = 64;
  localparam int MAX_LINES  = 64;

  localparam int BYTE_W       = 8;
  localparam int LINE_COUNT_W = 7;
  localparam int NUM_W        = 16;
  localparam int TOKEN_W      = 4;
  localparam int STATUS_W     = 2;

  localparam logic [TOKEN_W-1:0] FIELDS_PER_LINE = 4'd6;
  localparam logic [TOKEN_W-1:0] TOKEN_MAX       = 4'd15;

  localparam logic [7:0] CRC_POLY = 8'h07;

  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_PLUS  = 8'd43;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_0     = 8'd48;
  localparam logic [7:0] CHAR_9     = 8'd57;
  localparam logic [7:0] CHAR_E     = 8'd101;
  localparam logic [7:0] CHAR_N     = 8'd110;
  localparam logic [7:0] CHAR_D     = 8'd100;

  // end-word match position: 0..3 chars matched, or no match possible
  localparam logic [2:0] END_FULL = 3'd3;
  localparam logic [2:0] END_FAIL = 3'd4;

  localparam logic [NUM_W-1:0] DEC_WIDE_LIMIT = 16'd32768;
  localparam logic [NUM_W-1:0] DEC_POS_MAX    = 16'd32767;

  typedef enum logic [1:0] {
    DEC_SKIP,
    DEC_NUM,
    DEC_DONE
  } dec_phase_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_SHORT    = 2'd1,
    STATUS_MISMATCH = 2'd2
  } status_t;

  typedef struct packed {
    dec_phase_t phase;
    logic       sign_seen;
    logic       neg;
    logic       take;
  } dec_step_t;

  typedef struct packed {
    logic [BYTE_W-1:0]       cmd_type;
    logic [LINE_COUNT_W-1:0] line_count;
    logic signed [NUM_W-1:0] declared_length;
    logic signed [NUM_W-1:0] repeat_count;
    logic [BYTE_W-1:0]       checksum_received;
    logic [BYTE_W-1:0]       checksum_computed;
    status_t                 status;
  } report_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] x;
    x = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      x = x[7] ? ({x[6:0], 1'b0} ^ CRC_POLY) : {x[6:0], 1'b0};
    end
    return x;
  endfunction

  function automatic logic [7:0] end_char(input logic [1:0] pos);
    logic [7:0] ch;
    case (pos)
      2'd0:    ch = CHAR_E;
      2'd1:    ch = CHAR_N;
      2'd2:    ch = CHAR_D;
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

  // crc advanced over the held-back prefix of the end word
  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [2:0] pos);
    logic [7:0] x;
    x = crc;
    if (pos >= 3'd1) x = crc8_step(x, CHAR_E);
    if (pos >= 3'd2) x = crc8_step(x, CHAR_N);
    if (pos >= 3'd3) x = crc8_step(x, CHAR_D);
    return x;
  endfunction

  function automatic logic [3:0] dec_digit(input logic [7:0] c);
    logic [7:0] d;
    d = c - CHAR_0;
    return d[3:0];
  endfunction

  function automatic dec_step_t dec_step(input dec_phase_t phase, input logic [7:0] c);
    dec_step_t s;
    logic      digit;
    digit       = c inside {[CHAR_0:CHAR_9]};
    s.phase     = phase;
    s.sign_seen = 1'b0;
    s.neg       = (c == CHAR_MINUS);
    s.take      = 1'b0;
    case (phase)
      DEC_SKIP: begin
        if (c inside {[CHAR_TAB:CHAR_CR], CHAR_SPACE}) begin
          s.phase = DEC_SKIP;
        end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
          s.phase     = DEC_NUM;
          s.sign_seen = 1'b1;
        end else if (!digit) begin
          s.phase = DEC_DONE;
        end else begin
          s.phase = DEC_NUM;
          s.take  = 1'b1;
        end
      end
      DEC_NUM: begin
        if (!digit) begin
          s.phase = DEC_DONE;
        end else begin
          s.take = 1'b1;
        end
      end
      default: s.phase = DEC_DONE;
    endcase
    return s;
  endfunction

endpackage

### rtl/tmd_ifs.sv
// tmd_ifs: item channels of the text message deframer
interface tmd_rx_if;
  logic                      valid;
  logic                      ready;
  logic [tmd_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tmd_report_if;
  logic                                    valid;
  logic                                    ready;
  logic [tmd_pkg::BYTE_W-1:0]              cmd_type;
  logic [tmd_pkg::LINE_COUNT_W-1:0]        line_count;
  logic signed [tmd_pkg::NUM_W-1:0]        declared_length;
  logic signed [tmd_pkg::NUM_W-1:0]        repeat_count;
  logic [tmd_pkg::BYTE_W-1:0]              checksum_received;
  logic [tmd_pkg::BYTE_W-1:0]              checksum_computed;
  logic [tmd_pkg::STATUS_W-1:0]            status;

  modport source (output valid, output cmd_type, output line_count, output declared_length,
                  output repeat_count, output checksum_received, output checksum_computed,
                  output status, input ready);
  modport sink   (input valid, input cmd_type, input line_count, input declared_length,
                  input repeat_count, input checksum_received, input checksum_computed,
                  input status, output ready);
endinterface

### rtl/text_message_deframer_crc8_unit.sv
// text_message_deframer_crc8_unit: top level of the text message deframer with crc-8 check
// Takes one received byte per clock, sustained, as long as the report output is
// not blocked. Each byte is captured in an input register and its whole line,
// token, header, checksum and crc-8 update is done from that register; a
// newline that completes an "end" line loads one report into the output
// register. The only stall is a report that finds the output register still
// full, which holds that newline in the input register until the previous
// report is taken. No clearing pass follows reset.
module text_message_deframer_crc8_unit #(
  parameter int LINE_CHARS = tmd_pkg::LINE_CHARS,
  parameter int MAX_LINES  = tmd_pkg::MAX_LINES
) (
  input  logic          clk,
  input  logic          rst,
  tmd_rx_if.sink        rx,
  tmd_report_if.source  rpt
);

  logic                        b_valid;
  logic [tmd_pkg::BYTE_W-1:0]  b_byte;
  logic                        hit;
  logic                        stall;
  logic                        fire;
  tmd_pkg::report_t            report;

  assign fire     = b_valid && !(hit && stall);
  assign rx.ready = !b_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      b_valid <= 1'b1;
    end else if (fire) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) b_byte <= rx.rx_byte;
  end

  tmd_line_ctrl #(
    .LINE_CHARS (LINE_CHARS),
    .MAX_LINES  (MAX_LINES)
  ) u_line (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .c    (b_byte),
    .hit  (hit),
    .rpt  (report)
  );

  tmd_report_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (fire && hit),
    .d     (report),
    .stall (stall),
    .o     (rpt)
  );

  a_held_byte: assert property (@(posedge clk) disable iff (rst)
    b_valid && !fire |=> b_valid && $stable(b_byte))
    else $error("held item lost while report output blocked");

endmodule

### rtl/tmd_dec_acc.sv
// tmd_dec_acc: saturating signed decimal accumulator for one header number
module tmd_dec_acc (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             clr,
  input  logic                             feed,
  input  logic [tmd_pkg::BYTE_W-1:0]       c,
  output logic signed [tmd_pkg::NUM_W-1:0] value
);

  tmd_pkg::dec_phase_t         phase;
  logic                        neg;
  logic [tmd_pkg::NUM_W-1:0]   mag;
  tmd_pkg::dec_step_t          ds;
  logic [tmd_pkg::NUM_W+2:0]   m;
  logic [tmd_pkg::NUM_W-1:0]   mag_next;

  always_comb begin
    ds = tmd_pkg::dec_step(phase, c);
    m  = ((tmd_pkg::NUM_W+3)'(mag) << 3) + ((tmd_pkg::NUM_W+3)'(mag) << 1)
       + (tmd_pkg::NUM_W+3)'(tmd_pkg::dec_digit(c));
    if (m > (tmd_pkg::NUM_W+3)'(tmd_pkg::DEC_WIDE_LIMIT)) begin
      mag_next = tmd_pkg::DEC_WIDE_LIMIT;
    end else begin
      mag_next = m[tmd_pkg::NUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      phase <= tmd_pkg::DEC_SKIP;
      neg   <= 1'b0;
      mag   <= '0;
    end else if (feed) begin
      phase <= ds.phase;
      if (ds.sign_seen) neg <= ds.neg;
      if (ds.take) mag <= mag_next;
    end
  end

  // magnitude tops out at 32768, which only a negative value can use
  assign value = neg ? (tmd_pkg::NUM_W'(16'd0 - mag))
               : (mag > tmd_pkg::DEC_POS_MAX ? tmd_pkg::DEC_POS_MAX : mag);

endmodule

### rtl/tmd_line_ctrl.sv
// tmd_line_ctrl: per-byte line, token, header, checksum and crc state update
module tmd_line_ctrl #(
  parameter int LINE_CHARS = tmd_pkg::LINE_CHARS,
  parameter int MAX_LINES  = tmd_pkg::MAX_LINES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fire,
  input  logic [tmd_pkg::BYTE_W-1:0] c,
  output logic                       hit,
  output tmd_pkg::report_t           rpt
);

  localparam int CHARS_W = $clog2(LINE_CHARS);
  localparam int LINES_W = $clog2(MAX_LINES + 1);

  logic [CHARS_W-1:0]          chars, chars_next;
  logic [LINES_W-1:0]          lines, lines_next;
  logic [2:0]                  end_pos, end_pos_next;
  logic [7:0]                  crc_thru, crc_thru_next;
  logic [7:0]                  crc_before, crc_before_next;
  logic [7:0]                  header_type, header_type_next;
  logic [1:0]                  hdr_idx, hdr_idx_next;
  tmd_pkg::dec_phase_t         low_phase, low_phase_next;
  logic                        low_neg, low_neg_next;
  logic [7:0]                  low_mag, low_mag_next;
  logic [tmd_pkg::TOKEN_W-1:0] token_count, token_count_next;
  logic                        short_pend, short_pend_next;
  logic                        short_err, short_err_next;
  logic                        in_token, in_token_next;
  logic [7:0]                  footer, footer_next;

  logic                        live;
  logic                        crc_go;
  logic                        is_nl;
  logic                        keep;
  logic                        match;
  logic [7:0]                  folded;
  logic [7:0]                  base;
  logic [7:0]                  low_value;
  tmd_pkg::dec_step_t          ds;
  logic [1:0]                  t_clip;
  logic [1:0]                  idx_eff;
  logic                        len_feed;
  logic                        rep_feed;
  logic                        clr;
  logic                        have;
  logic signed [tmd_pkg::NUM_W-1:0] len_val;
  logic signed [tmd_pkg::NUM_W-1:0] rep_val;

  tmd_dec_acc u_len (
    .clk   (clk),
    .rst   (rst),
    .clr   (clr),
    .feed  (len_feed),
    .c     (c),
    .value (len_val)
  );

  tmd_dec_acc u_rep (
    .clk   (clk),
    .rst   (rst),
    .clr   (clr),
    .feed  (rep_feed),
    .c     (c),
    .value (rep_val)
  );

  always_comb begin
    live      = lines < LINES_W'(MAX_LINES);
    crc_go    = live && (lines != '0);
    is_nl     = (c == tmd_pkg::CHAR_NL);
    hit       = is_nl && (end_pos == tmd_pkg::END_FULL);
    clr       = fire && hit;
    keep      = chars < CHARS_W'(LINE_CHARS - 1);
    match     = (end_pos < tmd_pkg::END_FULL) && (c == tmd_pkg::end_char(end_pos[1:0]));
    folded    = tmd_pkg::crc_fold(crc_thru, end_pos);
    base      = ((end_pos != tmd_pkg::END_FAIL) && crc_go) ? folded : crc_thru;
    low_value = low_neg ? (8'd0 - low_mag) : low_mag;
    ds        = tmd_pkg::dec_step(low_phase, c);
    t_clip    = (token_count > 4'd3) ? 2'd3 : token_count[1:0];
    idx_eff   = (!in_token) ? t_clip : hdr_idx;

    chars_next       = chars;
    lines_next       = lines;
    end_pos_next     = end_pos;
    crc_thru_next    = crc_thru;
    crc_before_next  = crc_before;
    header_type_next = header_type;
    hdr_idx_next     = hdr_idx;
    low_phase_next   = low_phase;
    low_neg_next     = low_neg;
    low_mag_next     = low_mag;
    token_count_next = token_count;
    short_pend_next  = short_pend;
    short_err_next   = short_err;
    in_token_next    = in_token;
    footer_next      = footer;
    len_feed         = 1'b0;
    rep_feed         = 1'b0;

    if (fire) begin
      if (is_nl) begin
        if (!hit && live) begin
          if (end_pos != tmd_pkg::END_FAIL) begin
            crc_before_next = crc_thru;
            crc_thru_next   = crc_go ? folded : crc_thru;
          end
          short_err_next   = short_err | ((lines >= LINES_W'(2)) && short_pend);
          short_pend_next  = token_count < tmd_pkg::FIELDS_PER_LINE;
          footer_next      = low_value;
          lines_next       = lines + LINES_W'(1);
        end
        chars_next       = '0;
        end_pos_next     = '0;
        token_count_next = '0;
        in_token_next    = 1'b0;
        low_phase_next   = tmd_pkg::DEC_SKIP;
        low_neg_next     = 1'b0;
        low_mag_next     = '0;
      end else if (keep) begin
        chars_next = chars + CHARS_W'(1);
        if (match) begin
          end_pos_next = end_pos + 3'd1;
        end else begin
          if (end_pos != tmd_pkg::END_FAIL) begin
            end_pos_next = tmd_pkg::END_FAIL;
            if (live) crc_before_next = crc_thru;
          end
          crc_thru_next = crc_go ? tmd_pkg::crc8_step(base, c) : base;
        end
        if (live) begin
          low_phase_next = ds.phase;
          if (ds.sign_seen) low_neg_next = ds.neg;
          if (ds.take) begin
            low_mag_next = (low_mag << 3) + (low_mag << 1) + {4'd0, tmd_pkg::dec_digit(c)};
          end
          if (c == tmd_pkg::CHAR_SPACE) begin
            in_token_next = 1'b0;
          end else begin
            if (!in_token) begin
              in_token_next = 1'b1;
              if (token_count != tmd_pkg::TOKEN_MAX) begin
                token_count_next = token_count + 4'd1;
              end
              if (lines == '0) begin
                hdr_idx_next = t_clip;
                if (token_count == '0) header_type_next = c;
              end
            end
            len_feed = (lines == '0) && (idx_eff == 2'd1);
            rep_feed = (lines == '0) && (idx_eff == 2'd2);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      chars       <= '0;
      lines       <= '0;
      end_pos     <= '0;
      crc_thru    <= '0;
      crc_before  <= '0;
      header_type <= '0;
      hdr_idx     <= '0;
      low_phase   <= tmd_pkg::DEC_SKIP;
      low_neg     <= 1'b0;
      low_mag     <= '0;
      token_count <= '0;
      short_pend  <= 1'b0;
      short_err   <= 1'b0;
      in_token    <= 1'b0;
      footer      <= '0;
    end else begin
      chars       <= chars_next;
      lines       <= lines_next;
      end_pos     <= end_pos_next;
      crc_thru    <= crc_thru_next;
      crc_before  <= crc_before_next;
      header_type <= header_type_next;
      hdr_idx     <= hdr_idx_next;
      low_phase   <= low_phase_next;
      low_neg     <= low_neg_next;
      low_mag     <= low_mag_next;
      token_count <= token_count_next;
      short_pend  <= short_pend_next;
      short_err   <= short_err_next;
      in_token    <= in_token_next;
      footer      <= footer_next;
    end
  end

  always_comb begin
    have                  = (lines != '0);
    rpt.cmd_type          = have ? header_type : '0;
    rpt.line_count        = tmd_pkg::LINE_COUNT_W'(lines);
    rpt.declared_length   = have ? len_val : '0;
    rpt.repeat_count      = have ? rep_val : '0;
    rpt.checksum_received = footer;
    rpt.checksum_computed = crc_before;
    if (crc_before != footer) begin
      rpt.status = tmd_pkg::STATUS_MISMATCH;
    end else if (short_err) begin
      rpt.status = tmd_pkg::STATUS_SHORT;
    end else begin
      rpt.status = tmd_pkg::STATUS_OK;
    end
  end

  a_end_pos_range: assert property (@(posedge clk) disable iff (rst)
    end_pos <= tmd_pkg::END_FAIL)
    else $error("end match position out of range");

  a_chars_bound: assert property (@(posedge clk) disable iff (rst)
    chars <= CHARS_W'(LINE_CHARS - 1))
    else $error("line character count past limit");

  a_lines_bound: assert property (@(posedge clk) disable iff (rst)
    lines <= LINES_W'(MAX_LINES))
    else $error("stored line count past limit");

  a_clear_after_report: assert property (@(posedge clk) disable iff (rst)
    fire && hit |=> lines == '0 && crc_thru == '0 && end_pos == '0 && !short_err)
    else $error("message state not cleared after report");

endmodule

### rtl/tmd_report_reg.sv
// tmd_report_reg: output register holding one report item until taken
module tmd_report_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  tmd_pkg::report_t    d,
  output logic                stall,
  tmd_report_if.source        o
);

  logic             valid;
  tmd_pkg::report_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (o.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) held <= d;
  end

  assign stall               = valid && !o.ready;
  assign o.valid             = valid;
  assign o.cmd_type          = held.cmd_type;
  assign o.line_count        = held.line_count;
  assign o.declared_length   = held.declared_length;
  assign o.repeat_count      = held.repeat_count;
  assign o.checksum_received = held.checksum_received;
  assign o.checksum_computed = held.checksum_computed;
  assign o.status            = held.status;

endmodule

### tb/testbench.sv
// testbench for text_message_deframer_crc8_unit: byte-level predictor, message generator, checker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    tmd_pkg::dec_phase_t phase;
    logic                neg;
    int unsigned         mag;
  } num_acc_t;

  localparam logic [7:0] END_WORD [3] = '{tmd_pkg::CHAR_E, tmd_pkg::CHAR_N, tmd_pkg::CHAR_D};
  localparam int RANDOM_BYTES = 750;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 8;

  logic clk = 1'b0;
  logic rst;

  tmd_rx_if     rx_if ();
  tmd_report_if rpt_if ();

  text_message_deframer_crc8_unit u_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .rpt (rpt_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  int unsigned m_chars;
  int unsigned m_lines;
  int          m_end_pos;
  logic [7:0]  m_crc_run;
  logic [7:0]  m_crc_prev;
  logic [7:0]  m_type;
  logic [7:0]  m_footer;
  int          m_hdr_tok;
  num_acc_t    m_len;
  num_acc_t    m_rep;
  num_acc_t    m_line_num;
  int          m_tokens;
  logic        m_short_last;
  logic        m_short_any;
  logic        m_in_tok;

  tmd_pkg::report_t expected_reports [$];
  logic [7:0]       tx_bytes [$];

  int  bytes_sent;
  int  reports_predicted;
  int  reports_checked;
  int  errors;
  int  idle_cycles;
  int  hold_request;
  bit  hold_active;
  bit  no_gaps;

  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] x;
    x = crc ^ b;
    repeat (8) x = x[7] ? ((x << 1) ^ tmd_pkg::CRC_POLY) : (x << 1);
    return x;
  endfunction

  function automatic num_acc_t num_feed(input num_acc_t d, input logic [7:0] c, input bit wide);
    bit          digit;
    int unsigned m;
    digit = (c >= tmd_pkg::CHAR_0) && (c <= tmd_pkg::CHAR_9);
    if (d.phase == tmd_pkg::DEC_SKIP) begin
      if (c == tmd_pkg::CHAR_SPACE || (c >= tmd_pkg::CHAR_TAB && c <= tmd_pkg::CHAR_CR)) return d;
      if (c == tmd_pkg::CHAR_PLUS || c == tmd_pkg::CHAR_MINUS) begin
        d.neg   = (c == tmd_pkg::CHAR_MINUS);
        d.phase = tmd_pkg::DEC_NUM;
        return d;
      end
      if (!digit) begin
        d.phase = tmd_pkg::DEC_DONE;
        return d;
      end
      d.phase = tmd_pkg::DEC_NUM;
    end
    if (d.phase == tmd_pkg::DEC_NUM) begin
      if (!digit) begin
        d.phase = tmd_pkg::DEC_DONE;
        return d;
      end
      m = d.mag * 10 + (c - tmd_pkg::CHAR_0);
      if (wide) begin
        if (m > 32768) m = 32768;
      end else begin
        m = m & 32'hFF;
      end
      d.mag = m;
    end
    return d;
  endfunction

  function automatic logic signed [15:0] wide_value(input num_acc_t d);
    int unsigned v;
    if (d.neg) v = (0 - d.mag) & 32'hFFFF;
    else v = (d.mag > 32767) ? 32767 : d.mag;
    return v[15:0];
  endfunction

  function automatic logic [7:0] low_value(input num_acc_t d);
    int unsigned v;
    v = d.neg ? (0 - d.mag) : d.mag;
    return v[7:0];
  endfunction

  task automatic start_line();
    m_chars    = 0;
    m_end_pos  = 0;
    m_tokens   = 0;
    m_in_tok   = 1'b0;
    m_line_num = '{tmd_pkg::DEC_SKIP, 1'b0, 0};
  endtask

  task automatic clear_message();
    m_lines      = 0;
    m_crc_run    = 8'h00;
    m_crc_prev   = 8'h00;
    m_type       = 8'h00;
    m_hdr_tok    = 0;
    m_len        = '{tmd_pkg::DEC_SKIP, 1'b0, 0};
    m_rep        = '{tmd_pkg::DEC_SKIP, 1'b0, 0};
    m_short_last = 1'b0;
    m_short_any  = 1'b0;
    m_footer     = 8'h00;
    start_line();
  endtask

  // line cannot be the end word any more: fold the held-back prefix into the crc
  task automatic settle_line(input bit live);
    if (live) begin
      m_crc_prev = m_crc_run;
      if (m_lines >= 1)
        for (int i = 0; i < m_end_pos && i < 3; i++) m_crc_run = crc8_next(m_crc_run, END_WORD[i]);
    end
    m_end_pos = 4;
  endtask

  task automatic deframe_byte(input logic [7:0] c);
    bit               live;
    bit               have;
    int               t;
    tmd_pkg::report_t r;
    live = m_lines < tmd_pkg::MAX_LINES;
    if (c == tmd_pkg::CHAR_NL) begin
      if (m_end_pos == 3) begin
        have                = m_lines >= 1;
        r.cmd_type          = have ? m_type : 8'h00;
        r.line_count        = m_lines[tmd_pkg::LINE_COUNT_W-1:0];
        r.declared_length   = have ? wide_value(m_len) : 16'sd0;
        r.repeat_count      = have ? wide_value(m_rep) : 16'sd0;
        r.checksum_received = m_footer;
        r.checksum_computed = m_crc_prev;
        if (m_crc_prev != m_footer) r.status = tmd_pkg::STATUS_MISMATCH;
        else if (m_short_any) r.status = tmd_pkg::STATUS_SHORT;
        else r.status = tmd_pkg::STATUS_OK;
        expected_reports.push_back(r);
        reports_predicted++;
        clear_message();
        return;
      end
      if (live) begin
        if (m_end_pos != 4) settle_line(1'b1);
        if (m_lines >= 2 && m_short_last) m_short_any = 1'b1;
        m_short_last = m_tokens < tmd_pkg::FIELDS_PER_LINE;
        m_footer     = low_value(m_line_num);
        m_lines++;
      end
      start_line();
      return;
    end
    if (m_chars >= tmd_pkg::LINE_CHARS - 1) return;
    m_chars++;
    if (m_end_pos < 3 && c == END_WORD[m_end_pos]) begin
      m_end_pos++;
    end else begin
      if (m_end_pos != 4) settle_line(live);
      if (live && m_lines >= 1) m_crc_run = crc8_next(m_crc_run, c);
    end
    if (!live) return;
    m_line_num = num_feed(m_line_num, c, 1'b0);
    if (c == tmd_pkg::CHAR_SPACE) begin
      m_in_tok = 1'b0;
      return;
    end
    if (!m_in_tok) begin
      m_in_tok = 1'b1;
      t = m_tokens;
      if (m_tokens < tmd_pkg::TOKEN_MAX) m_tokens++;
      if (m_lines == 0) begin
        m_hdr_tok = (t < 3) ? t : 3;
        if (t == 0) m_type = c;
      end
    end
    if (m_lines == 0) begin
      if (m_hdr_tok == 1) m_len = num_feed(m_len, c, 1'b1);
      else if (m_hdr_tok == 2) m_rep = num_feed(m_rep, c, 1'b1);
    end
  endtask

  function automatic int gap_cycles();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = gap_cycles();
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic send_queued();
    foreach (tx_bytes[i]) send_byte(tx_bytes[i]);
    tx_bytes.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) tx_bytes.push_back(s[i]);
  endtask

  function automatic logic [7:0] rand_char(input bit any_byte);
    logic [7:0] c;
    do begin
      c = any_byte ? 8'($urandom_range(0, 255)) : 8'($urandom_range(33, 126));
    end while (c == tmd_pkg::CHAR_NL || c == tmd_pkg::CHAR_SPACE);
    return c;
  endfunction

  function automatic int header_value();
    case ($urandom_range(0, 9))
      0:       return 32767;
      1:       return -32768;
      2:       return 32768 + $urandom_range(0, 100000);
      3:       return -32769 - int'($urandom_range(0, 100000));
      default: return int'($urandom_range(0, 4000)) - 2000;
    endcase
  endfunction

  task automatic add_decimal(input int v);
    case ($urandom_range(0, 7))
      0:       add_text($sformatf("+%0d", v));
      1:       add_text($sformatf("\t%0d", v));
      2:       add_text($sformatf("%0dx7", v));
      3:       add_text($sformatf("00%0d", v));
      default: add_text($sformatf("%0d", v));
    endcase
  endtask

  task automatic add_header(input int ntok);
    tx_bytes.push_back(rand_char($urandom_range(0, 3) == 0));
    if (ntok >= 2) begin
      add_text(" ");
      add_decimal(header_value());
    end
    if (ntok >= 3) begin
      add_text(" ");
      add_decimal(header_value());
    end
    if (ntok >= 4) begin
      add_text(" ");
      tx_bytes.push_back(rand_char(1'b1));
    end
    tx_bytes.push_back(tmd_pkg::CHAR_NL);
  endtask

  task automatic add_data_line(input int ntok, input bit any_byte, inout logic [7:0] crc);
    int first;
    first = tx_bytes.size();
    if ($urandom_range(0, 7) == 0) tx_bytes.push_back(tmd_pkg::CHAR_SPACE);
    for (int t = 0; t < ntok; t++) begin
      if (t > 0) repeat ($urandom_range(1, 2)) tx_bytes.push_back(tmd_pkg::CHAR_SPACE);
      repeat ($urandom_range(1, 3)) tx_bytes.push_back(rand_char(any_byte));
    end
    for (int i = first; i < tx_bytes.size(); i++) crc = crc8_next(crc, tx_bytes[i]);
    tx_bytes.push_back(tmd_pkg::CHAR_NL);
  endtask

  task automatic add_footer(input logic [7:0] crc, input bit correct);
    int v;
    v = correct ? int'(crc) : int'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) add_text(" ");
    case ($urandom_range(0, 5))
      0:       add_text($sformatf("%0d", v + 256 * int'($urandom_range(1, 40))));
      1:       add_text($sformatf("-%0d", 256 - v));
      2:       add_text($sformatf("+%0d", v));
      default: add_text($sformatf("%0d", v));
    endcase
    tx_bytes.push_back(tmd_pkg::CHAR_NL);
  endtask

  task automatic send_message(input int ndata, input int min_tok, input bit good_footer);
    logic [7:0] crc;
    crc = 8'h00;
    add_header(($urandom_range(0, 9) < 7) ? 3 : $urandom_range(0, 4));
    for (int i = 0; i < ndata; i++)
      add_data_line($urandom_range(min_tok, 8), $urandom_range(0, 3) == 0, crc);
    add_footer(crc, good_footer);
    add_text("end\n");
    send_queued();
  endtask

  // mostly empty lines so the line limit is reached cheaply
  task automatic send_many_lines(input int nlines);
    logic [7:0] crc;
    crc = 8'h00;
    add_text("L 5 9\n");
    for (int i = 0; i < nlines - 2; i++) begin
      if (i % 16 == 0) add_data_line(6, 1'b0, crc);
      else add_text("\n");
    end
    add_footer(crc, 1'b1);
    add_text("end\n");
    send_queued();
  endtask

  task automatic test_empty_and_single_line();
    add_text("end\n");
    add_text("\nend\n");
    add_text("42\nend\n");
    send_queued();
  endtask

  task automatic test_header_limits();
    add_text("Z 32767 -32768\nend\n");
    add_text("q 99999 -40000 7\nend\n");
    send_queued();
  endtask

  task automatic test_status_priority();
    logic [7:0] crc;
    crc = 8'h00;
    add_text("A 1 2\n");
    add_data_line(2, 1'b0, crc);
    add_footer(crc, 1'b1);
    add_text("end\n");
    crc = 8'h00;
    add_text("B 3 4\n");
    add_data_line(1, 1'b0, crc);
    add_text("\n");
    add_footer(crc ^ 8'h5A, 1'b1);
    add_text("end\n");
    send_queued();
  endtask

  task automatic test_odd_bytes();
    add_text("Z 1 1\n");
    tx_bytes.push_back(8'h00);
    add_text(" 1 2 3 4 ");
    tx_bytes.push_back(8'hFF);
    add_text("\n0\nend\n");
    send_queued();
  endtask

  task automatic test_output_stall();
    rx_if.valid  <= 1'b0;
    hold_request = 300;
    do @(posedge clk); while (!hold_active);
    no_gaps = 1'b1;
    repeat (8) add_text("end\n");
    send_queued();
    no_gaps = 1'b0;
  endtask

  task automatic test_random_traffic();
    int         msg;
    int         kind;
    logic [7:0] crc;
    msg = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 7) == 0) no_gaps = !no_gaps;
      kind = $urandom_range(0, 19);
      if (msg == 1) begin
        send_many_lines(70);
      end else if (msg == 3) begin
        send_many_lines(64);
      end else if (kind < 13) begin
        send_message($urandom_range(0, 2), 6, $urandom_range(0, 9) != 0);
      end else if (kind == 13) begin
        send_message(1, 0, 1'b1);
      end else if (kind == 14) begin
        // long data line, mostly past the character limit of a line
        crc = 8'h00;
        add_header(3);
        add_data_line($urandom_range(25, 35), 1'b0, crc);
        add_footer(crc, 1'b1);
        add_text("end\n");
        send_queued();
      end else if (kind == 15) begin
        repeat ($urandom_range(1, 20)) tx_bytes.push_back(8'($urandom_range(0, 255)));
        send_queued();
      end else if (kind == 16) begin
        // message cut off before its end line
        crc = 8'h00;
        add_header(3);
        add_data_line(6, 1'b0, crc);
        send_queued();
      end else if (kind == 17) begin
        case ($urandom_range(0, 3))
          0:       add_text(" end\n");
          1:       add_text("ends\n");
          2:       add_text("en\n");
          default: add_text("end\t\n");
        endcase
        add_text("end\n");
        send_queued();
      end else if (kind == 18) begin
        add_header($urandom_range(0, 4));
        add_text("end\n");
        send_queued();
      end else begin
        add_text("end\n");
        send_queued();
      end
      msg++;
    end
    no_gaps = 1'b0;
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s expected %0d got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : report_checker
    tmd_pkg::report_t want;
    if (!rst && rpt_if.valid && rpt_if.ready) begin
      if (expected_reports.size() == 0) begin
        $error("report with none expected");
        errors++;
      end else begin
        want = expected_reports.pop_front();
        check_field("cmd_type", want.cmd_type, rpt_if.cmd_type);
        check_field("line_count", want.line_count, rpt_if.line_count);
        check_field("declared_length", int'(want.declared_length), int'(rpt_if.declared_length));
        check_field("repeat_count", int'(want.repeat_count), int'(rpt_if.repeat_count));
        check_field("checksum_received", want.checksum_received, rpt_if.checksum_received);
        check_field("checksum_computed", want.checksum_computed, rpt_if.checksum_computed);
        check_field("status", int'(want.status), int'(rpt_if.status));
      end
      reports_checked++;
    end
  end

  always @(posedge clk) begin
    if ((rx_if.valid && rx_if.ready) || (rpt_if.valid && rpt_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin : report_ready_driver
    int stall;
    rpt_if.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        stall        = hold_request;
        hold_request = 0;
        hold_active  = 1'b1;
        rpt_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        hold_active  = 1'b0;
      end else begin
        stall = gap_cycles();
        if (stall > 0) begin
          rpt_if.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        rpt_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : run_tests
    int waited;
    rst           = 1'b1;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = 8'h00;
    clear_message();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_and_single_line();
    test_header_limits();
    test_status_priority();
    test_odd_bytes();
    test_output_stall();
    test_random_traffic();

    rx_if.valid <= 1'b0;
    waited = 0;
    while (expected_reports.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_reports.size() != 0) begin
      $error("%0d reports never arrived", expected_reports.size());
      errors++;
    end

    $display("sent %0d bytes: empty, single-line, saturated, short, mismatched and overlong",
             bytes_sent);
    $display("messages plus line-limit and output-stall runs; %0d reports checked, %0d errors",
             reports_checked, errors);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
